>>> hw/rtl/ipac_pkg.sv
// ----------------------------------------------------------------------------
// ipac_pkg
// Shared types and constants for the icon pixel alpha cleanup block
// ----------------------------------------------------------------------------
package ipac_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_THRESHOLD    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREMULTIPLY_ENABLE = 2'd2;

    // pixel modes
    localparam logic [1:0] MODE_PASS      = 2'd0;
    localparam logic [1:0] MODE_COLOR_KEY = 2'd1;
    localparam logic [1:0] MODE_LIFT      = 2'd2;
    localparam logic [1:0] MODE_THRESHOLD = 2'd3;

    localparam logic [7:0] LIFT_LEVEL      = 8'h0A;
    localparam logic [7:0] FULL_ALPHA      = 8'hFF;
    localparam logic [7:0] THRESHOLD_RESET = 8'd25;
    localparam int unsigned PREMUL_SHIFT   = 8;

    typedef struct packed {
        logic       last_pixel;
        logic       first_pixel;
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic       last_out;
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    typedef struct packed {
        logic [1:0] pixel_mode;
        logic [7:0] alpha_threshold;
        logic       premultiply_enable;
    } cfg_t;

    function automatic logic near_black(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
        near_black = (b < LIFT_LEVEL) && (g < LIFT_LEVEL) && (r < LIFT_LEVEL);
    endfunction

    function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
        logic [15:0] prod;
        prod = {8'd0, c} * {8'd0, a};
        premul = prod[PREMUL_SHIFT +: 8];
    endfunction

endpackage

>>> hw/rtl/icon_pixel_alpha_cleanup_top.sv
// ----------------------------------------------------------------------------
// icon_pixel_alpha_cleanup_top
// Two-register pixel pipeline: input register, cleanup logic, result register
// ----------------------------------------------------------------------------
//  channel  | signals                              | payload
//  ---------+--------------------------------------+---------------------
//  pixel    | pixel_valid, pixel_stall             | ipac_pkg::pixel_in_t
//  result   | result_valid, result_stall           | ipac_pkg::pixel_out_t
//  config   | cfg_write, cfg_index, cfg_data       | 8-bit register data
//
//  one pixel transaction per cycle sustained while the result is not stalled;
//  an accepted pixel goes through the input register, then the result register
//  the whole pipeline advances when the result register is empty or taken
//  a stalled result backs up into the input register, then stalls the input
//  reset restores the configuration defaults and clears valid flags and the color key
// ----------------------------------------------------------------------------
module icon_pixel_alpha_cleanup_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ipac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  ipac_pkg::pixel_in_t                pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output ipac_pkg::pixel_out_t               result
);

    ipac_pkg::cfg_t       cfg;
    ipac_pkg::pixel_in_t  pix_reg;
    ipac_pkg::pixel_out_t res_reg;
    ipac_pkg::pixel_out_t res_next;
    logic                 pix_valid_reg;
    logic                 res_valid_reg;
    logic                 advance;
    logic                 take_in;

    ipac_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance     = !res_valid_reg || !result_stall;
    assign pixel_stall = pix_valid_reg && !advance;
    assign take_in     = pixel_valid && !pixel_stall;

    ipac_pixel_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix_reg),
        .fire  (pix_valid_reg && advance),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                res_valid_reg <= pix_valid_reg;
            end
            if (advance || !pix_valid_reg)
            begin
                pix_valid_reg <= pixel_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            pix_reg <= pixel;
        end
        if (advance && pix_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (pix_valid_reg && res_valid_reg))
        else $error("input stalled with room in the pipeline");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && !advance) |=> (pix_valid_reg && $stable(pix_reg)))
        else $error("input register changed while blocked");

    a_move_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && advance) |=> res_valid_reg)
        else $error("pixel lost between stages");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take_in |=> pix_valid_reg)
        else $error("accepted transaction not held in input register");

endmodule

>>> hw/rtl/ipac_cfg_regs.sv
// ----------------------------------------------------------------------------
// ipac_cfg_regs
// Configuration register file with plain write port
// ----------------------------------------------------------------------------
module ipac_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ipac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipac_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ipac_pkg::cfg_t                     cfg
);

    ipac_pkg::cfg_t cfg_reg;
    ipac_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ipac_pkg::REG_PIXEL_MODE:         cfg_next.pixel_mode = cfg_data[1:0];
                ipac_pkg::REG_ALPHA_THRESHOLD:    cfg_next.alpha_threshold = cfg_data;
                ipac_pkg::REG_PREMULTIPLY_ENABLE: cfg_next.premultiply_enable = cfg_data[0];
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_mode         <= ipac_pkg::MODE_PASS;
            cfg_reg.alpha_threshold    <= ipac_pkg::THRESHOLD_RESET;
            cfg_reg.premultiply_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/ipac_pixel_core.sv
// ----------------------------------------------------------------------------
// ipac_pixel_core
// Per-pixel cleanup logic and color key register
// ----------------------------------------------------------------------------
module ipac_pixel_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ipac_pkg::cfg_t         cfg,
    input  ipac_pkg::pixel_in_t    pix,
    input  logic                   fire,
    output ipac_pkg::pixel_out_t   res
);

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic [31:0] word;
    logic        key_hit;
    logic [7:0]  pb;
    logic [7:0]  pg;
    logic [7:0]  pr;

    assign word = {pix.alpha_in, pix.red_in, pix.green_in, pix.blue_in};

    assign key_hit = pix.first_pixel || (word == key_reg);

    always_comb
    begin
        key_next = key_reg;
        if (fire && (cfg.pixel_mode == ipac_pkg::MODE_COLOR_KEY) && pix.first_pixel)
        begin
            key_next = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // optional premultiply for threshold mode
    always_comb
    begin
        pb = pix.blue_in;
        pg = pix.green_in;
        pr = pix.red_in;
        if (cfg.premultiply_enable)
        begin
            pb = ipac_pkg::premul(pix.blue_in, pix.alpha_in);
            pg = ipac_pkg::premul(pix.green_in, pix.alpha_in);
            pr = ipac_pkg::premul(pix.red_in, pix.alpha_in);
        end
    end

    always_comb
    begin
        res.last_out  = pix.last_pixel;
        res.blue_out  = pix.blue_in;
        res.green_out = pix.green_in;
        res.red_out   = pix.red_in;
        res.alpha_out = pix.alpha_in;
        case (cfg.pixel_mode)
            ipac_pkg::MODE_PASS:
            begin
                res.alpha_out = pix.alpha_in;
            end
            ipac_pkg::MODE_COLOR_KEY:
            begin
                if (key_hit)
                begin
                    res.blue_out  = '0;
                    res.green_out = '0;
                    res.red_out   = '0;
                    res.alpha_out = '0;
                end
                else if (ipac_pkg::near_black(pix.blue_in, pix.green_in, pix.red_in))
                begin
                    res.blue_out  = ipac_pkg::LIFT_LEVEL;
                    res.green_out = ipac_pkg::LIFT_LEVEL;
                    res.red_out   = ipac_pkg::LIFT_LEVEL;
                    res.alpha_out = ipac_pkg::FULL_ALPHA;
                end
            end
            ipac_pkg::MODE_LIFT:
            begin
                if (ipac_pkg::near_black(pix.blue_in, pix.green_in, pix.red_in))
                begin
                    res.blue_out  = ipac_pkg::LIFT_LEVEL;
                    res.green_out = ipac_pkg::LIFT_LEVEL;
                    res.red_out   = ipac_pkg::LIFT_LEVEL;
                end
            end
            ipac_pkg::MODE_THRESHOLD:
            begin
                if (pix.alpha_in < cfg.alpha_threshold)
                begin
                    res.blue_out  = '0;
                    res.green_out = '0;
                    res.red_out   = '0;
                    res.alpha_out = '0;
                end
                else if (ipac_pkg::near_black(pb, pg, pr))
                begin
                    res.blue_out  = ipac_pkg::LIFT_LEVEL;
                    res.green_out = ipac_pkg::LIFT_LEVEL;
                    res.red_out   = ipac_pkg::LIFT_LEVEL;
                end
                else
                begin
                    res.blue_out  = pb;
                    res.green_out = pg;
                    res.red_out   = pr;
                end
            end
            default:
            begin
                res.alpha_out = pix.alpha_in;
            end
        endcase
    end

endmodule

>>> sim/pixel_cleanup_checker.sv
// ----------------------------------------------------------------------------
// pixel_cleanup_checker
// Watches the config, pixel and result channels of the cleanup block, keeps
// its own copy of the registers and the color key, predicts each cleaned
// pixel and compares every result transaction field by field
// ----------------------------------------------------------------------------
module pixel_cleanup_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ipac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ipac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               pixel_valid,
    input  logic                               pixel_stall,
    input  ipac_pkg::pixel_in_t                pixel,
    input  logic                               result_valid,
    input  logic                               result_stall,
    input  ipac_pkg::pixel_out_t               result,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked
);

    ipac_pkg::pixel_out_t  expected_pixels[$];
    ipac_pkg::pixel_out_t  want;
    ipac_pkg::cfg_t        shadow_cfg;
    logic [31:0]           shadow_key;
    int                    errors;
    int                    matched;

    function automatic logic below_lift(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
        below_lift = (b < ipac_pkg::LIFT_LEVEL) && (g < ipac_pkg::LIFT_LEVEL) &&
                     (r < ipac_pkg::LIFT_LEVEL);
    endfunction

    function automatic ipac_pkg::pixel_out_t clean_pixel(input ipac_pkg::pixel_in_t p,
                                                         input ipac_pkg::cfg_t c,
                                                         input logic [31:0] key);
        logic [7:0]            b;
        logic [7:0]            g;
        logic [7:0]            r;
        logic [7:0]            a;
        logic [15:0]           prod_b;
        logic [15:0]           prod_g;
        logic [15:0]           prod_r;
        ipac_pkg::pixel_out_t  o;
        b = p.blue_in;
        g = p.green_in;
        r = p.red_in;
        a = p.alpha_in;
        case (c.pixel_mode)
            ipac_pkg::MODE_COLOR_KEY:
            begin
                if ({a, r, g, b} == key)
                begin
                    {a, r, g, b} = 32'd0;
                end
                else if (below_lift(b, g, r))
                begin
                    {r, g, b} = {ipac_pkg::LIFT_LEVEL, ipac_pkg::LIFT_LEVEL,
                                 ipac_pkg::LIFT_LEVEL};
                    a = ipac_pkg::FULL_ALPHA;
                end
            end
            ipac_pkg::MODE_LIFT:
            begin
                if (below_lift(b, g, r))
                begin
                    {r, g, b} = {ipac_pkg::LIFT_LEVEL, ipac_pkg::LIFT_LEVEL,
                                 ipac_pkg::LIFT_LEVEL};
                end
            end
            ipac_pkg::MODE_THRESHOLD:
            begin
                if (c.premultiply_enable)
                begin
                    prod_b = {8'd0, b} * {8'd0, a};
                    prod_g = {8'd0, g} * {8'd0, a};
                    prod_r = {8'd0, r} * {8'd0, a};
                    b = prod_b[15:8];
                    g = prod_g[15:8];
                    r = prod_r[15:8];
                end
                if (a < c.alpha_threshold)
                begin
                    {a, r, g, b} = 32'd0;
                end
                else if (below_lift(b, g, r))
                begin
                    {r, g, b} = {ipac_pkg::LIFT_LEVEL, ipac_pkg::LIFT_LEVEL,
                                 ipac_pkg::LIFT_LEVEL};
                end
            end
            default:
            begin
            end
        endcase
        o.blue_out  = b;
        o.green_out = g;
        o.red_out   = r;
        o.alpha_out = a;
        o.last_out  = p.last_pixel;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned exp_val);
        errors++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 matched, field, got, exp_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            shadow_cfg.pixel_mode         = ipac_pkg::MODE_PASS;
            shadow_cfg.alpha_threshold    = ipac_pkg::THRESHOLD_RESET;
            shadow_cfg.premultiply_enable = 1'b0;
            shadow_key = 32'd0;
            errors     = 0;
            matched    = 0;
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("result with none expected",
                                    {result.alpha_out, result.red_out,
                                     result.green_out, result.blue_out}, 0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result.blue_out !== want.blue_out)
                        report_mismatch("blue", result.blue_out, want.blue_out);
                    if (result.green_out !== want.green_out)
                        report_mismatch("green", result.green_out, want.green_out);
                    if (result.red_out !== want.red_out)
                        report_mismatch("red", result.red_out, want.red_out);
                    if (result.alpha_out !== want.alpha_out)
                        report_mismatch("alpha", result.alpha_out, want.alpha_out);
                    if (result.last_out !== want.last_out)
                        report_mismatch("last", result.last_out, want.last_out);
                    matched++;
                end
            end
            if (pixel_valid && !pixel_stall)
            begin
                if (shadow_cfg.pixel_mode == ipac_pkg::MODE_COLOR_KEY && pixel.first_pixel)
                begin
                    shadow_key = {pixel.alpha_in, pixel.red_in, pixel.green_in,
                                  pixel.blue_in};
                end
                expected_pixels.push_back(clean_pixel(pixel, shadow_cfg, shadow_key));
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    ipac_pkg::REG_PIXEL_MODE:
                        shadow_cfg.pixel_mode = cfg_data[1:0];
                    ipac_pkg::REG_ALPHA_THRESHOLD:
                        shadow_cfg.alpha_threshold = cfg_data;
                    ipac_pkg::REG_PREMULTIPLY_ENABLE:
                        shadow_cfg.premultiply_enable = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            fail_count <= errors;
            pending    <= expected_pixels.size();
            checked    <= matched;
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the icon pixel alpha cleanup block with directed corner pixels and
// then random image streams over many register settings, with random idling
// on both channels and long result holds; the checker beside the block
// predicts and compares, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [ipac_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned RANDOM_PHASES = 14;
    localparam int unsigned PHASE_ITEMS   = 100;
    localparam int unsigned LONG_HOLD     = 40;
    localparam int unsigned IDLE_LIMIT    = 1000;
    localparam int unsigned END_PAUSE     = 4;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_write;
    logic [ipac_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [ipac_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                              pixel_valid;
    logic                              pixel_stall;
    ipac_pkg::pixel_in_t               pixel;
    logic                              result_valid;
    logic                              result_stall;
    ipac_pkg::pixel_out_t              result;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned pixels_sent;
    int unsigned phases;
    int unsigned idle_cycles;
    logic [31:0] stim_key;
    int unsigned stim_threshold;
    bit          sender_burst;

    icon_pixel_alpha_cleanup_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    pixel_cleanup_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    function automatic ipac_pkg::pixel_in_t make_pixel(input logic [7:0] b,
                                                       input logic [7:0] g,
                                                       input logic [7:0] r,
                                                       input logic [7:0] a,
                                                       input logic first,
                                                       input logic last);
        ipac_pkg::pixel_in_t p;
        p.blue_in     = b;
        p.green_in    = g;
        p.red_in      = r;
        p.alpha_in    = a;
        p.first_pixel = first;
        p.last_pixel  = last;
        return p;
    endfunction

    // mix of key copies, near-key, near-black, threshold edges and noise
    function automatic ipac_pkg::pixel_in_t random_pixel();
        logic [31:0] bits;
        logic [31:0] word;
        int unsigned lvl;
        bits = $urandom;
        case ($urandom_range(0, 7))
            0, 1: word = stim_key;
            2:    word = stim_key ^ (32'd1 << $urandom_range(0, 31));
            3:    word = {bits[31:24], 4'd0, bits[19:16], 4'd0, bits[11:8], 4'd0, bits[3:0]};
            4:
            begin
                lvl  = stim_threshold + $urandom_range(0, 4);
                lvl  = (lvl < 2) ? 0 : ((lvl > 257) ? 255 : lvl - 2);
                word = {lvl[7:0], 3'd0, bits[20:16], 3'd0, bits[12:8], 3'd0, bits[4:0]};
            end
            default: word = bits;
        endcase
        return {2'b00, word};
    endfunction

    function automatic void pixel_sent_count();
        pixels_sent++;
    endfunction

    task automatic send_pixel(input ipac_pkg::pixel_in_t p);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do @(posedge clk); while (pixel_stall);
        pixel_sent_count();
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ipac_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ipac_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == ipac_pkg::REG_ALPHA_THRESHOLD)
            stim_threshold = val;
    endtask

    task automatic send_image(input int unsigned len, input bit broken);
        ipac_pkg::pixel_in_t p;
        logic [31:0]         bits;
        int unsigned         i;
        sender_burst = ($urandom_range(0, 3) == 0);
        for (i = 0; i < len; i++)
        begin
            p    = random_pixel();
            bits = $urandom;
            if (broken)
            begin
                p.first_pixel = bits[0];
                p.last_pixel  = bits[1];
            end
            else
            begin
                p.first_pixel = (i == 0);
                p.last_pixel  = (i == len - 1);
            end
            if (p.first_pixel)
                stim_key = {p.alpha_in, p.red_in, p.green_in, p.blue_in};
            send_pixel(p);
        end
    endtask

    // result side: random stall before each transaction, no-stall stretches,
    // and a long hold now and then while the sender is offering
    initial
    begin : receiver
        int unsigned gap;
        int unsigned taken;
        int unsigned next_hold;
        taken     = 0;
        next_hold = 300;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken >= next_hold && pixel_valid)
            begin
                gap       = LONG_HOLD;
                next_hold = next_hold + 500;
            end
            else if (taken % 128 < 24)
                gap = 0;
            else
                gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!(result_valid && !result_stall));
            taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned k;
        int unsigned phase_sent;
        int unsigned len;
        bit          paused;
        logic [31:0] bits;
        logic [7:0]  thr;
        cfg_write   <= 1'b0;
        cfg_index   <= ipac_pkg::REG_PIXEL_MODE;
        cfg_data    <= '0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        rst_n       <= 1'b0;
        pixels_sent    = 0;
        phases         = 0;
        stim_key       = 32'd0;
        stim_threshold = ipac_pkg::THRESHOLD_RESET;
        sender_burst   = 1'b0;
        paused         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass mode after reset, first pixel must not latch a key
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1));
        send_pixel(make_pixel(8'h05, 8'h03, 8'h01, 8'h00, 1'b1, 1'b1));

        // color key: reset key of zero, lift, latch, exact and near matches
        write_reg(ipac_pkg::REG_PIXEL_MODE, {6'd0, ipac_pkg::MODE_COLOR_KEY});
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h04, 8'h09, 8'h00, 8'h7F, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b1, 1'b0));
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h41, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h09, 8'h09, 8'h09, 8'h00, 1'b0, 1'b1));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));

        // lift only, premultiply set but unused here
        write_reg(ipac_pkg::REG_PIXEL_MODE, {6'd0, ipac_pkg::MODE_LIFT});
        write_reg(ipac_pkg::REG_PREMULTIPLY_ENABLE, 8'd1);
        send_pixel(make_pixel(8'h09, 8'h09, 8'h09, 8'h33, 1'b1, 1'b0));
        send_pixel(make_pixel(8'h0A, 8'h00, 8'h00, 8'h33, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1));

        // threshold: default, zero, full, then premultiply
        write_reg(ipac_pkg::REG_PIXEL_MODE, {6'd0, ipac_pkg::MODE_THRESHOLD});
        write_reg(ipac_pkg::REG_PREMULTIPLY_ENABLE, 8'd0);
        send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 8'h18, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h19, 1'b1, 1'b0));
        write_reg(ipac_pkg::REG_ALPHA_THRESHOLD, 8'd0);
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
        write_reg(ipac_pkg::REG_ALPHA_THRESHOLD, 8'd255);
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hFE, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 8'hFF, 1'b0, 1'b1));
        write_reg(ipac_pkg::REG_ALPHA_THRESHOLD, 8'd0);
        write_reg(ipac_pkg::REG_PREMULTIPLY_ENABLE, 8'd1);
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h10, 8'h10, 8'h10, 8'hFF, 1'b0, 1'b0));
        send_pixel(make_pixel(8'h12, 8'h12, 8'h12, 8'h80, 1'b0, 1'b1));

        // out-of-range index ignored, key kept across other modes
        write_reg(REG_SPARE, 8'hFF);
        write_reg(ipac_pkg::REG_PIXEL_MODE, {6'd0, ipac_pkg::MODE_COLOR_KEY});
        send_pixel(make_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0, 1'b1));
        stim_key = 32'h40302010;

        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            bits = $urandom;
            thr  = (k == 3) ? 8'd0 : ((k == 7) ? 8'd255 : bits[15:8]);
            write_reg(ipac_pkg::REG_PIXEL_MODE, {bits[7:2], k[1:0]});
            write_reg(ipac_pkg::REG_ALPHA_THRESHOLD, thr);
            write_reg(ipac_pkg::REG_PREMULTIPLY_ENABLE, {bits[23:17], ~k[2]});
            write_reg(REG_SPARE, bits[31:24]);
            phases++;
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                  : $urandom_range(1, 12);
                send_image(len, $urandom_range(0, 9) == 0);
                phase_sent += len;
                if (k == 5 && !paused && phase_sent >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (END_PAUSE) @(posedge clk);
        $display("covered %0d pixels and %0d checked results over %0d random settings",
                 pixels_sent, checked, phases);
        $display("all four modes, thresholds 0 and 255, premultiply on and off, long holds");
        if (fail_count == 0 && pending == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
